### hdl/magic_framed_packet_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAGIC_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define MAGIC_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH
`define MFPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFPD_ASSERT_IMPL(lbl, ante, cons, msg)
`define MFPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/mfpd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Shared types, frame constants and verdict codes.
// ----------------------------------------------------------------------------
package mfpd_pkg;

  localparam logic [7:0] MAGIC_0 = 8'h45;
  localparam logic [7:0] MAGIC_1 = 8'h67;
  localparam logic [7:0] TAIL_0  = 8'h89;
  localparam logic [7:0] TAIL_1  = 8'hAB;

  localparam logic [23:0] MAX_LEN_RESET = 24'h010000;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HEAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_LENGTH     = 3'd2;
  localparam logic [2:0] ST_TAIL       = 3'd3;
  localparam logic [2:0] ST_SHORT      = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_DATA    = 3'b010,
    PH_DISCARD = 3'b100
  } phase_t;

  typedef struct packed {
    logic        has_pay;
    logic        has_ver;
    logic [7:0]  data_byte;
    logic        section;
    logic [2:0]  status;
    logic [31:0] session;
    logic [15:0] command;
    logic [15:0] head_length;
    logic [31:0] body_length;
  } entry_t;

endpackage

### hdl/mfpd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Parses the byte stream and turns payload and verdict bytes into queue entries.
// ----------------------------------------------------------------------------
module mfpd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_data_byte,
  input  logic            in_buffer_last,
  input  logic [31:0]     in_session_id,
  input  logic            q_full,
  input  logic [23:0]     max_len,
  output logic            push,
  output mfpd_pkg::entry_t push_entry
);

  mfpd_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] pos_r, pos_nxt, pos_inc;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [16:0] hend_r, hend_nxt;
  logic [23:0] bend_r, bend_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        tfo_r, tfo_nxt;
  logic        acc;
  logic        has_pay, has_ver, sect, to_discard, done;
  logic [2:0]  ver_st;
  logic [32:0] lsum;

  assign acc     = in_valid && !q_full;
  assign pos_inc = pos_r + 24'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    hlen_nxt   = hlen_r;
    blen_nxt   = blen_r;
    hend_nxt   = hend_r;
    bend_nxt   = bend_r;
    pend_nxt   = pend_r;
    tfo_nxt    = tfo_r;
    has_pay    = 1'b0;
    has_ver    = 1'b0;
    sect       = 1'b0;
    ver_st     = mfpd_pkg::ST_OK;
    to_discard = 1'b0;
    done       = 1'b0;
    lsum       = '0;
    case (phase_r)
      mfpd_pkg::PH_HEADER: begin
        if (pos_r == '0) begin
          cmd_nxt  = '0;
          hlen_nxt = '0;
          blen_nxt = '0;
          pend_nxt = mfpd_pkg::ST_OK;
          tfo_nxt  = 1'b0;
        end
        case (pos_r[3:0])
          4'd0: if (in_data_byte != mfpd_pkg::MAGIC_0) pend_nxt = mfpd_pkg::ST_HEAD_MAGIC;
          4'd1: if (in_data_byte != mfpd_pkg::MAGIC_1) pend_nxt = mfpd_pkg::ST_HEAD_MAGIC;
          4'd2: cmd_nxt = {in_data_byte, 8'h00};
          4'd3: cmd_nxt = {cmd_r[15:8], in_data_byte};
          4'd4: hlen_nxt = {in_data_byte, 8'h00};
          4'd5: hlen_nxt = {hlen_r[15:8], in_data_byte};
          4'd6, 4'd7, 4'd8: blen_nxt = {blen_r[23:0], in_data_byte};
          4'd9: begin
            blen_nxt = {blen_r[23:0], in_data_byte};
            lsum     = {17'd0, hlen_r} + {1'b0, blen_nxt};
            hend_nxt = {1'b0, hlen_r} + 17'd10;
            bend_nxt = lsum[23:0] + 24'd10;
            if (pend_r == mfpd_pkg::ST_OK && (lsum + 33'd12) > {9'd0, max_len}) begin
              pend_nxt = mfpd_pkg::ST_LENGTH;
            end
          end
          default: ;
        endcase
      end
      mfpd_pkg::PH_DATA: begin
        if (pend_r != mfpd_pkg::ST_OK) begin
          if (pos_r == 24'd11) begin
            has_ver    = 1'b1;
            ver_st     = pend_r;
            to_discard = 1'b1;
          end
        end else if (pos_r < {7'd0, hend_r}) begin
          has_pay = 1'b1;
        end else if (pos_r < bend_r) begin
          has_pay = 1'b1;
          sect    = 1'b1;
        end else if (pos_r == bend_r) begin
          tfo_nxt = (in_data_byte == mfpd_pkg::TAIL_0);
        end else begin
          has_ver = 1'b1;
          if (tfo_r && in_data_byte == mfpd_pkg::TAIL_1) begin
            ver_st = mfpd_pkg::ST_OK;
            done   = 1'b1;
          end else begin
            ver_st     = mfpd_pkg::ST_TAIL;
            to_discard = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (phase_r == mfpd_pkg::PH_DISCARD) begin
      pos_nxt = '0;
      if (in_buffer_last) phase_nxt = mfpd_pkg::PH_HEADER;
    end else if (to_discard) begin
      pos_nxt   = '0;
      phase_nxt = in_buffer_last ? mfpd_pkg::PH_HEADER : mfpd_pkg::PH_DISCARD;
    end else if (done) begin
      pos_nxt   = '0;
      phase_nxt = mfpd_pkg::PH_HEADER;
    end else if (in_buffer_last) begin
      has_ver   = 1'b1;
      ver_st    = (pos_r < 24'd11) ? mfpd_pkg::ST_SHORT : mfpd_pkg::ST_LENGTH;
      pos_nxt   = '0;
      phase_nxt = mfpd_pkg::PH_HEADER;
    end else begin
      pos_nxt   = pos_inc;
      phase_nxt = (pos_inc >= 24'd10) ? mfpd_pkg::PH_DATA : mfpd_pkg::PH_HEADER;
    end
  end

  assign push                   = acc && (has_pay || has_ver);
  assign push_entry.has_pay     = has_pay;
  assign push_entry.has_ver     = has_ver;
  assign push_entry.data_byte   = in_data_byte;
  assign push_entry.section     = sect;
  assign push_entry.status      = ver_st;
  assign push_entry.session     = in_session_id;
  assign push_entry.command     = cmd_nxt;
  assign push_entry.head_length = hlen_nxt;
  assign push_entry.body_length = blen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mfpd_pkg::PH_HEADER;
      pos_r   <= '0;
      cmd_r   <= '0;
      hlen_r  <= '0;
      blen_r  <= '0;
      hend_r  <= '0;
      bend_r  <= '0;
      pend_r  <= mfpd_pkg::ST_OK;
      tfo_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
      hlen_r  <= hlen_nxt;
      blen_r  <= blen_nxt;
      hend_r  <= hend_nxt;
      bend_r  <= bend_nxt;
      pend_r  <= pend_nxt;
      tfo_r   <= tfo_nxt;
    end
  end

endmodule

### hdl/mfpd_queue.sv
// ----------------------------------------------------------------------------
// Deframer entry queue
// Short first-in first-out store between front end and back end.
// ----------------------------------------------------------------------------
module mfpd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  mfpd_pkg::entry_t             wr_entry,
  input  logic                         pop,
  output mfpd_pkg::entry_t             rd_entry,
  output logic                         full,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  mfpd_pkg::entry_t q_mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == LW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;
  assign rd_entry  = q_mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + LW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/mfpd_back.sv
// ----------------------------------------------------------------------------
// Deframer back end
// Expands queue entries into result transfers through an output register.
// ----------------------------------------------------------------------------
module mfpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mfpd_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_section,
  output logic [31:0]      out_session_tag,
  output logic [15:0]      out_command,
  output logic [15:0]      out_head_length,
  output logic [31:0]      out_body_length,
  output logic [2:0]       out_status,
  output logic             out_run_last
);

  logic        valid_r, valid_nxt;
  logic        second_r, second_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        sect_r, sect_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        last_r, last_nxt;
  logic        load, emit_pay;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    sect_nxt   = sect_r;
    sess_nxt   = sess_r;
    cmd_nxt    = cmd_r;
    hlen_nxt   = hlen_r;
    blen_nxt   = blen_r;
    st_nxt     = st_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    emit_pay   = q_entry.has_pay && !second_r;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        kind_nxt = !emit_pay;
        byte_nxt = emit_pay ? q_entry.data_byte : 8'h00;
        sect_nxt = emit_pay ? q_entry.section : 1'b0;
        st_nxt   = emit_pay ? mfpd_pkg::ST_OK : q_entry.status;
        sess_nxt = q_entry.session;
        cmd_nxt  = q_entry.command;
        hlen_nxt = q_entry.head_length;
        blen_nxt = q_entry.body_length;
        if (emit_pay && q_entry.has_ver) begin
          second_nxt = 1'b1;
          last_nxt   = 1'b0;
        end else begin
          second_nxt = 1'b0;
          last_nxt   = 1'b1;
          q_pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    sect_r <= sect_nxt;
    sess_r <= sess_nxt;
    cmd_r  <= cmd_nxt;
    hlen_r <= hlen_nxt;
    blen_r <= blen_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_result_kind  = kind_r;
  assign out_payload_byte = byte_r;
  assign out_section      = sect_r;
  assign out_session_tag  = sess_r;
  assign out_command      = cmd_r;
  assign out_head_length  = hlen_r;
  assign out_body_length  = blen_r;
  assign out_status       = st_r;
  assign out_run_last     = last_r;

endmodule

### hdl/magic_framed_packet_deframer_top.sv
// Path: a result passes through the queue and then the output register
// before it can transfer.
// Throughput: one byte per cycle while the queue is not full; a byte that
// yields a payload byte and a verdict holds the output for both, absorbed by the queue.
// Reset: synchronous, active low; parser returns to frame start, queue
// empties, output goes idle and the length limit returns to 65536.
// ----------------------------------------------------------------------------
// Magic-framed packet deframer
// Front end parses frames, queue decouples, back end drives result transfers.
// ----------------------------------------------------------------------------
`include "magic_framed_packet_deframer_top_macros.svh"

module magic_framed_packet_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_last,
  input  logic [31:0] in_session_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_section,
  output logic [31:0] out_session_tag,
  output logic [15:0] out_command,
  output logic [15:0] out_head_length,
  output logic [31:0] out_body_length,
  output logic [2:0]  out_status,
  output logic        out_run_last
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [23:0]      max_len_r;
  logic             push, pop, q_full, q_valid;
  logic [LVL_W-1:0] q_level;
  mfpd_pkg::entry_t push_entry, head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= mfpd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;

  mfpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_buffer_last (in_buffer_last),
    .in_session_id  (in_session_id),
    .q_full         (q_full),
    .max_len        (max_len_r),
    .push           (push),
    .push_entry     (push_entry)
  );

  mfpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (push_entry),
    .pop       (pop),
    .rd_entry  (head_entry),
    .full      (q_full),
    .not_empty (q_valid),
    .level     (q_level)
  );

  mfpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (head_entry),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_section      (out_section),
    .out_session_tag  (out_session_tag),
    .out_command      (out_command),
    .out_head_length  (out_head_length),
    .out_body_length  (out_body_length),
    .out_status       (out_status),
    .out_run_last     (out_run_last)
  );

  `MFPD_ASSERT_IMPL(a_level_bound, 1'b1, q_level <= LVL_W'(QUEUE_DEPTH), "queue level overrun")
  `MFPD_ASSERT_IMPL(a_pay_status, out_valid && !out_result_kind, out_status == mfpd_pkg::ST_OK, "payload with status")
  `MFPD_ASSERT_IMPL(a_ver_clean, out_valid && out_result_kind, out_payload_byte == 8'h00 && !out_section, "verdict with data")
  `MFPD_ASSERT_NEXT(a_pay_then_ver, out_valid && !out_stall && !out_result_kind && !out_run_last, out_valid && out_result_kind && out_run_last, "verdict missing after payload")

endmodule

### bench/mfpd_frame_checker.sv
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches the byte and result channels, mirrors the frame parser to predict
// payload and verdict transfers, and compares every result against the oldest
// prediction. Reports a failure count and the number of results still owed.
// ----------------------------------------------------------------------------
module mfpd_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_last,
  input  logic [31:0] in_session_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_section,
  input  logic [31:0] out_session_tag,
  input  logic [15:0] out_command,
  input  logic [15:0] out_head_length,
  input  logic [31:0] out_body_length,
  input  logic [2:0]  out_status,
  input  logic        out_run_last,
  output int          error_count,
  output int          outstanding,
  output int          payload_seen,
  output int          verdicts_seen,
  output int          rejects_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;
  localparam logic SECT_HEAD    = 1'b0;
  localparam logic SECT_BODY    = 1'b1;
  localparam int   REPORT_LIMIT = 10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic        section;
    logic [31:0] tag;
    logic [15:0] command;
    logic [15:0] head_len;
    logic [31:0] body_len;
    logic [2:0]  status;
    logic        run_last;
  } deframe_result_t;

  deframe_result_t expected_q[$];

  mfpd_pkg::phase_t parse_phase;
  logic [23:0]      byte_pos;
  logic [23:0]      len_limit;
  logic [15:0]      cmd_q;
  logic [15:0]      head_len_q;
  logic [31:0]      body_len_q;
  logic [2:0]       held_error;
  logic             tail_lead_ok;

  function automatic logic [33:0] frame_len();
    return {18'd0, head_len_q} + {2'd0, body_len_q} + 34'd12;
  endfunction

  function automatic deframe_result_t make_result(input logic kind, input logic [7:0] data,
                                                  input logic sect, input logic [31:0] tag,
                                                  input logic [2:0] status);
    deframe_result_t r;
    r.kind     = kind;
    r.payload  = data;
    r.section  = sect;
    r.tag      = tag;
    r.command  = cmd_q;
    r.head_len = head_len_q;
    r.body_len = body_len_q;
    r.status   = status;
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic clear_parser();
    parse_phase  = mfpd_pkg::PH_HEADER;
    byte_pos     = '0;
    len_limit    = mfpd_pkg::MAX_LEN_RESET;
    cmd_q        = '0;
    head_len_q   = '0;
    body_len_q   = '0;
    held_error   = mfpd_pkg::ST_OK;
    tail_lead_ok = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last, input logic [31:0] tag);
    deframe_result_t res [2];
    int              n;
    int              k;
    logic [23:0]     pos;
    logic [33:0]     head_end;
    logic [33:0]     body_end;
    logic            finished;
    logic [2:0]      st;
    n        = 0;
    pos      = byte_pos;
    finished = 1'b0;
    if (parse_phase == mfpd_pkg::PH_DISCARD) begin
      if (last) begin
        parse_phase = mfpd_pkg::PH_HEADER;
        byte_pos    = '0;
      end
    end else begin
      if (pos == 24'd0) begin
        cmd_q        = '0;
        head_len_q   = '0;
        body_len_q   = '0;
        held_error   = mfpd_pkg::ST_OK;
        tail_lead_ok = 1'b0;
      end
      if (pos < 24'd10) begin
        case (pos)
          24'd0: if (b != mfpd_pkg::MAGIC_0) held_error = mfpd_pkg::ST_HEAD_MAGIC;
          24'd1: if (b != mfpd_pkg::MAGIC_1) held_error = mfpd_pkg::ST_HEAD_MAGIC;
          24'd2: cmd_q = {b, 8'h00};
          24'd3: cmd_q[7:0] = b;
          24'd4: head_len_q = {b, 8'h00};
          24'd5: head_len_q[7:0] = b;
          default: begin
            body_len_q = {body_len_q[23:0], b};
            if (pos == 24'd9 && held_error == mfpd_pkg::ST_OK &&
                frame_len() > {10'd0, len_limit})
              held_error = mfpd_pkg::ST_LENGTH;
          end
        endcase
      end else if (held_error != mfpd_pkg::ST_OK) begin
        if (pos == 24'd11) begin
          res[n] = make_result(KIND_VERDICT, 8'h00, SECT_HEAD, tag, held_error);
          n++;
          parse_phase = mfpd_pkg::PH_DISCARD;
        end
      end else begin
        head_end = 34'd10 + {18'd0, head_len_q};
        body_end = head_end + {2'd0, body_len_q};
        if ({10'd0, pos} < head_end) begin
          res[n] = make_result(KIND_PAYLOAD, b, SECT_HEAD, tag, mfpd_pkg::ST_OK);
          n++;
        end else if ({10'd0, pos} < body_end) begin
          res[n] = make_result(KIND_PAYLOAD, b, SECT_BODY, tag, mfpd_pkg::ST_OK);
          n++;
        end else if ({10'd0, pos} == frame_len() - 34'd2) begin
          tail_lead_ok = (b == mfpd_pkg::TAIL_0);
        end else begin
          st = (tail_lead_ok && b == mfpd_pkg::TAIL_1) ? mfpd_pkg::ST_OK : mfpd_pkg::ST_TAIL;
          res[n] = make_result(KIND_VERDICT, 8'h00, SECT_HEAD, tag, st);
          n++;
          finished    = 1'b1;
          parse_phase = (st == mfpd_pkg::ST_OK) ? mfpd_pkg::PH_HEADER : mfpd_pkg::PH_DISCARD;
        end
      end

      if (parse_phase == mfpd_pkg::PH_DISCARD) begin
        byte_pos = '0;
        if (last) parse_phase = mfpd_pkg::PH_HEADER;
      end else if (finished) begin
        byte_pos    = '0;
        parse_phase = mfpd_pkg::PH_HEADER;
      end else if (last) begin
        res[n] = make_result(KIND_VERDICT, 8'h00, SECT_HEAD, tag,
                             (pos < 24'd11) ? mfpd_pkg::ST_SHORT : mfpd_pkg::ST_LENGTH);
        n++;
        byte_pos    = '0;
        parse_phase = mfpd_pkg::PH_HEADER;
      end else begin
        byte_pos    = pos + 24'd1;
        parse_phase = (byte_pos >= 24'd10) ? mfpd_pkg::PH_DATA : mfpd_pkg::PH_HEADER;
      end

      for (k = 0; k < n; k++) begin
        if (k == n - 1) res[k].run_last = 1'b1;
        expected_q.insert(expected_q.size(), res[k]);
      end
    end
  endtask

  task automatic show_result(input string label, input deframe_result_t r);
    $display("  %s kind=%0d byte=%02h sect=%0d tag=%08h cmd=%04h hlen=%0d blen=%0d",
             label, r.kind, r.payload, r.section, r.tag, r.command, r.head_len, r.body_len);
    $display("       st=%0d last=%0d", r.status, r.run_last);
  endtask

  task automatic check_result();
    deframe_result_t got;
    deframe_result_t want;
    got = {out_result_kind, out_payload_byte, out_section, out_session_tag, out_command,
           out_head_length, out_body_length, out_status, out_run_last};
    if (got.kind == KIND_PAYLOAD) payload_seen++;
    else begin
      verdicts_seen++;
      if (got.status != mfpd_pkg::ST_OK) rejects_seen++;
    end
    if (expected_q.size() == 0) begin
      if (error_count < REPORT_LIMIT) begin
        $display("Unexpected result transfer at %0t", $realtime);
        show_result("got ", got);
      end
      error_count++;
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        if (error_count < REPORT_LIMIT) begin
          $display("Result mismatch at %0t", $realtime);
          show_result("want", want);
          show_result("got ", got);
        end
        error_count++;
      end
    end
  endtask

  initial clear_parser();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (cfg_wr_en) len_limit = cfg_wr_data;
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_buffer_last, in_session_id);
      if (out_valid && !out_stall) check_result();
    end
    outstanding = expected_q.size();
  end

endmodule

### bench/magic_framed_packet_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds receive buffers of magic-framed packets, clean and damaged, through
// several length limits with random gaps and stalls on both channels, and
// takes the verdict from the result checker running beside the block.
// ----------------------------------------------------------------------------
module magic_framed_packet_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC_LEAD,
    FLAW_MAGIC_TRAIL,
    FLAW_TAIL_LEAD,
    FLAW_TAIL_TRAIL
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_buffer_last;
  logic [31:0] in_session_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic        out_section;
  logic [31:0] out_session_tag;
  logic [15:0] out_command;
  logic [15:0] out_head_length;
  logic [31:0] out_body_length;
  logic [2:0]  out_status;
  logic        out_run_last;

  int error_count;
  int outstanding;
  int payload_seen;
  int verdicts_seen;
  int rejects_seen;

  logic [7:0] stream_q[$];
  logic       calm;
  logic       hold_request;
  int         hold_left;
  int         bytes_sent;
  int         buffers_sent;
  int         limits_written;

  magic_framed_packet_deframer_top dut (.*);

  mfpd_frame_checker u_checker (.*);

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_stall    = 1'b0;
    hold_request = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 30);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_buffer_last <= last;
    in_session_id  <= $urandom();
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_stream();
    int k;
    for (k = 0; k < stream_q.size(); k++) send_byte(stream_q[k], k == stream_q.size() - 1);
    bytes_sent += stream_q.size();
    buffers_sent++;
    stream_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  task automatic push_header(input logic [15:0] cmd, input logic [15:0] hlen,
                             input logic [31:0] blen, input flaw_t flaw);
    logic [7:0] spoil;
    spoil = 8'($urandom_range(1, 255));
    add_byte(flaw == FLAW_MAGIC_LEAD ? mfpd_pkg::MAGIC_0 ^ spoil : mfpd_pkg::MAGIC_0);
    add_byte(flaw == FLAW_MAGIC_TRAIL ? mfpd_pkg::MAGIC_1 ^ spoil : mfpd_pkg::MAGIC_1);
    add_byte(cmd[15:8]);
    add_byte(cmd[7:0]);
    add_byte(hlen[15:8]);
    add_byte(hlen[7:0]);
    add_byte(blen[31:24]);
    add_byte(blen[23:16]);
    add_byte(blen[15:8]);
    add_byte(blen[7:0]);
  endtask

  task automatic push_junk(input int count);
    repeat (count) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_tail(input flaw_t flaw);
    logic [7:0] spoil;
    spoil = 8'($urandom_range(1, 255));
    add_byte(flaw == FLAW_TAIL_LEAD ? mfpd_pkg::TAIL_0 ^ spoil : mfpd_pkg::TAIL_0);
    add_byte(flaw == FLAW_TAIL_TRAIL ? mfpd_pkg::TAIL_1 ^ spoil : mfpd_pkg::TAIL_1);
  endtask

  task automatic push_frame(input logic [15:0] cmd, input logic [15:0] hlen,
                            input logic [31:0] blen, input flaw_t flaw);
    push_header(cmd, hlen, blen, flaw);
    push_junk(int'({16'd0, hlen} + blen));
    push_tail(flaw);
  endtask

  task automatic trim_stream(input int count);
    repeat (count) stream_q.delete(stream_q.size() - 1);
  endtask

  task automatic build_random_buffer();
    int          frames;
    int          f;
    int          pick;
    int          mark;
    logic        stop;
    logic [15:0] hlen;
    logic [31:0] blen;
    frames = $urandom_range(1, 3);
    stop   = 1'b0;
    for (f = 0; f < frames && !stop; f++) begin
      hlen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(8, 40))
                                         : 16'($urandom_range(0, 5));
      blen = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(8, 40))
                                         : 32'($urandom_range(0, 5));
      pick = $urandom_range(0, 99);
      if (pick < 68) push_frame(16'($urandom()), hlen, blen, FLAW_NONE);
      else if (pick < 74) push_frame(16'($urandom()), hlen, blen, FLAW_MAGIC_LEAD);
      else if (pick < 80) push_frame(16'($urandom()), hlen, blen, FLAW_MAGIC_TRAIL);
      else if (pick < 86) push_frame(16'($urandom()), hlen, blen, FLAW_TAIL_LEAD);
      else if (pick < 92) push_frame(16'($urandom()), hlen, blen, FLAW_TAIL_TRAIL);
      else if (pick < 96) begin
        mark = stream_q.size();
        push_frame(16'($urandom()), hlen, blen, FLAW_NONE);
        trim_stream($urandom_range(1, stream_q.size() - mark - 1));
        stop = 1'b1;
      end else begin
        push_header(16'($urandom()), 16'($urandom()), $urandom(), FLAW_NONE);
        push_junk($urandom_range(0, 16));
        stop = 1'b1;
      end
    end
    if (!stop && $urandom_range(0, 5) == 0) push_junk($urandom_range(1, 11));
  endtask

  task automatic run_random(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_random_buffer();
      send_stream();
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [23:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limits_written++;
  endtask

  initial begin
    int waited;
    int mid;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_buffer_last = 1'b0;
    in_session_id  = '0;
    calm           = 1'b0;
    bytes_sent     = 0;
    buffers_sent   = 0;
    limits_written = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit: every verdict kind, back-to-back frames, discard, wide lengths
    push_frame(16'h0000, 16'd0, 32'd0, FLAW_NONE);
    send_stream();
    push_header(16'hFFFF, 16'd2, 32'd3, FLAW_NONE);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    push_tail(FLAW_NONE);
    push_frame(16'h1234, 16'd1, 32'd0, FLAW_NONE);
    send_stream();
    push_frame(16'hA5A5, 16'd1, 32'd2, FLAW_MAGIC_LEAD);
    push_frame(16'h0001, 16'd1, 32'd1, FLAW_NONE);
    send_stream();
    push_frame(16'h5A5A, 16'd2, 32'd0, FLAW_MAGIC_TRAIL);
    send_stream();
    push_header(16'hC3C3, 16'hFFFF, 32'hFFFF_FFFF, FLAW_NONE);
    push_junk(6);
    send_stream();
    push_frame(16'h0F0F, 16'd1, 32'd1, FLAW_TAIL_LEAD);
    push_frame(16'h0002, 16'd0, 32'd0, FLAW_NONE);
    send_stream();
    push_frame(16'hF0F0, 16'd0, 32'd2, FLAW_TAIL_TRAIL);
    send_stream();
    push_junk(5);
    send_stream();
    push_header(16'h7777, 16'd0, 32'd0, FLAW_MAGIC_LEAD);
    push_junk(1);
    send_stream();
    push_frame(16'h0404, 16'd4, 32'd0, FLAW_NONE);
    trim_stream(stream_q.size() - 12);
    send_stream();
    push_frame(16'h0202, 16'd0, 32'd2, FLAW_NONE);
    trim_stream(1);
    send_stream();
    add_byte(mfpd_pkg::MAGIC_0);
    send_stream();
    settle();

    // tightest legal limit: only empty frames fit
    write_limit(24'd12);
    push_frame(16'h1111, 16'd0, 32'd0, FLAW_NONE);
    push_frame(16'h2222, 16'd0, 32'd0, FLAW_NONE);
    send_stream();
    push_frame(16'h3333, 16'd0, 32'd1, FLAW_NONE);
    send_stream();
    run_random(100);
    settle();

    // widest limit, with a calm stretch and a long receiver hold-off
    write_limit(24'hFF_FFFF);
    calm = 1'b1;
    hold_request = 1'b1;
    push_frame(16'hBEEF, 16'd30, 32'd30, FLAW_NONE);
    send_stream();
    run_random(100);
    calm = 1'b0;
    run_random(150);
    settle();

    // limit below any frame: every frame is rejected
    write_limit(24'd11);
    push_frame(16'h4444, 16'd0, 32'd0, FLAW_NONE);
    send_stream();
    run_random(60);
    settle();

    mid = $urandom_range(30, 50);
    write_limit(24'(mid));
    push_frame(16'h5555, 16'd0, 32'(mid - 12), FLAW_NONE);
    send_stream();
    push_frame(16'h6666, 16'd1, 32'(mid - 12), FLAW_NONE);
    send_stream();
    run_random(150);
    settle();

    write_limit(mfpd_pkg::MAX_LEN_RESET);
    run_random(200);

    in_valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d byte transfers in %0d buffers under %0d length limits",
             bytes_sent, buffers_sent, limits_written + 1);
    $display("Checked %0d payload bytes and %0d frame verdicts, %0d of them rejections",
             payload_seen, verdicts_seen, rejects_seen);
    if (error_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
